[hw/rtl/jte_pkg.sv]
// Package with the beat types and operation and status codes of the job table engine.
package jte_pkg;

  localparam int unsigned PidW = 22;
  localparam int unsigned JobKeyW = 5;
  localparam int unsigned RunW = 2;
  localparam int unsigned CountOutW = 5;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_DEL_PID = 3'd1;
  localparam logic [2:0] OP_DEL_JOB = 3'd2;
  localparam logic [2:0] OP_FIND_PID = 3'd3;
  localparam logic [2:0] OP_FIND_JOB = 3'd4;
  localparam logic [2:0] OP_FOREGROUND = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_PID = 2'd3;

  localparam logic [RunW-1:0] RUN_FOREGROUND = 2'd1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [PidW-1:0]    pid_key;
    logic [JobKeyW-1:0] job_key;
    logic [RunW-1:0]    run_state;
  } jte_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PidW-1:0]      found_pid;
    logic [JobKeyW-1:0]   found_job;
    logic [RunW-1:0]      found_state;
    logic [CountOutW-1:0] live_count;
  } jte_out_t;

endpackage

[hw/rtl/job_table_engine.sv]
// Job table engine: a table of job entries in one memory, scanned by a sequencer.
// An add or a find scans the memory up to the first matching or free entry; a delete scans for
// the match, then rescans the whole table for the highest job number. Scans read one entry a cycle.
// Throughput: one item at a time; the next input beat is taken once the result is registered.
// Reset clears the entry valid bits and the count and sets the next job number to one at once; there
// is no clearing pass, and items are accepted as soon as reset is released.
module job_table_engine #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jte_pkg::jte_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jte_pkg::jte_out_t out_data_o
);
  import jte_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned JW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);
  localparam logic [JW:0] DepthW = (JW + 1)'(TABLE_DEPTH);
  localparam logic [JW-1:0] JobOne = JW'(1);

  typedef struct packed {
    logic [PidW-1:0] pid;
    logic [JW-1:0]   job;
    logic [RunW-1:0] st;
  } ent_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_ADD  = 6'b000100,
    S_DEL  = 6'b001000,
    S_MAX  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  ent_t                   mem [TABLE_DEPTH];
  ent_t                   rdata_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  state_e                 state_q;
  jte_in_t                in_q;
  jte_out_t               res_q;
  jte_out_t               out_q;
  logic                   out_vld_q;
  logic                   rd_on_q;
  logic [AW-1:0]          rd_addr_q;
  logic                   pipe_vld_q;
  logic [AW-1:0]          cmp_addr_q;
  logic [AW-1:0]          hit_q;
  logic [JW-1:0]          next_job_q;
  logic [JW-1:0]          count_q;
  logic [JW-1:0]          top_q;

  logic          cmp_valid;
  logic          cmp_last;
  logic          match;
  logic [JW-1:0] cand;
  logic [JW-1:0] top_d;
  logic [JW:0]   top_inc;
  logic [JW:0]   nj_inc;
  logic [JW-1:0] nj_add_d;
  logic [JW-1:0] nj_del_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign cmp_valid = valid_q[cmp_addr_q];
  assign cmp_last  = (cmp_addr_q == LastAddr);

  always_comb begin
    case (in_q.opcode)
      OP_ADD:                    match = !cmp_valid;
      OP_DEL_PID, OP_FIND_PID:   match = cmp_valid && (rdata_q.pid == in_q.pid_key);
      OP_DEL_JOB, OP_FIND_JOB:   match = cmp_valid && (32'(rdata_q.job) == 32'(in_q.job_key));
      OP_FOREGROUND:             match = cmp_valid && (rdata_q.st == RUN_FOREGROUND);
      default:                   match = 1'b0;
    endcase
  end

  assign cand     = (pipe_vld_q && cmp_valid) ? rdata_q.job : '0;
  assign top_d    = (cand > top_q) ? cand : top_q;
  assign top_inc  = {1'b0, top_d} + (JW + 1)'(1);
  assign nj_del_d = (top_inc > DepthW) ? JobOne : top_inc[JW-1:0];
  assign nj_inc   = {1'b0, next_job_q} + (JW + 1)'(1);
  assign nj_add_d = (nj_inc > DepthW) ? JobOne : nj_inc[JW-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_on_q) begin
      rdata_q <= mem[rd_addr_q];
    end
    if (state_q == S_ADD) begin
      mem[hit_q] <= '{pid: in_q.pid_key, job: next_job_q, st: in_q.run_state};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      out_vld_q  <= 1'b0;
      rd_on_q    <= 1'b0;
      rd_addr_q  <= '0;
      pipe_vld_q <= 1'b0;
      cmp_addr_q <= '0;
      hit_q      <= '0;
      next_job_q <= JobOne;
      count_q    <= '0;
      top_q      <= '0;
      in_q       <= '0;
      res_q      <= '0;
      out_q      <= '0;
    end else begin
      pipe_vld_q <= rd_on_q;
      cmp_addr_q <= rd_addr_q;
      if (rd_on_q) begin
        if (rd_addr_q == LastAddr) begin
          rd_on_q <= 1'b0;
        end else begin
          rd_addr_q <= rd_addr_q + AW'(1);
        end
      end
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q  <= in_data_i;
            res_q <= '0;
            case (in_data_i.opcode)
              OP_ADD, OP_DEL_PID, OP_DEL_JOB, OP_FIND_PID, OP_FIND_JOB,
              OP_FOREGROUND: begin
                if (in_data_i.opcode == OP_ADD && in_data_i.pid_key == '0) begin
                  res_q.status <= ST_BAD_PID;
                  state_q      <= S_DONE;
                end else begin
                  rd_on_q   <= 1'b1;
                  rd_addr_q <= '0;
                  state_q   <= S_SCAN;
                end
              end
              default: begin
                res_q.status <= ST_NOT_FOUND;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (pipe_vld_q && match) begin
            rd_on_q           <= 1'b0;
            pipe_vld_q        <= 1'b0;
            hit_q             <= cmp_addr_q;
            res_q.status      <= ST_OK;
            res_q.found_pid   <= rdata_q.pid;
            res_q.found_job   <= JobKeyW'(rdata_q.job);
            res_q.found_state <= rdata_q.st;
            case (in_q.opcode)
              OP_ADD:                 state_q <= S_ADD;
              OP_DEL_PID, OP_DEL_JOB: state_q <= S_DEL;
              default:                state_q <= S_DONE;
            endcase
          end else if (pipe_vld_q && cmp_last) begin
            res_q.status <= (in_q.opcode == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
            state_q      <= S_DONE;
          end
        end
        S_ADD: begin
          valid_q[hit_q]    <= 1'b1;
          count_q           <= count_q + JW'(1);
          next_job_q        <= nj_add_d;
          res_q.found_pid   <= in_q.pid_key;
          res_q.found_job   <= JobKeyW'(next_job_q);
          res_q.found_state <= in_q.run_state;
          state_q           <= S_DONE;
        end
        S_DEL: begin
          valid_q[hit_q] <= 1'b0;
          if (count_q != '0) begin
            count_q <= count_q - JW'(1);
          end
          top_q     <= '0;
          rd_on_q   <= 1'b1;
          rd_addr_q <= '0;
          state_q   <= S_MAX;
        end
        S_MAX: begin
          top_q <= top_d;
          if (pipe_vld_q && cmp_last) begin
            next_job_q <= nj_del_d;
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_q        <= 1'b1;
            out_q            <= res_q;
            out_q.live_count <= CountOutW'(count_q);
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sim/job_table_engine_test.sv]
// Self-checking testbench for the job table engine with a scoreboard class and random idling.
`timescale 1ns / 100ps

module job_table_engine_test;
  import jte_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 10;
  localparam logic [PidW-1:0] PID_MAX = '1;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam logic [RunW-1:0] RUN_UNDEFINED = 2'd0;
  localparam logic [RunW-1:0] RUN_BACKGROUND = 2'd2;
  localparam logic [RunW-1:0] RUN_STOPPED = 2'd3;

  class job_table_mirror;
    logic [PidW-1:0]    slot_pid [DEPTH];
    logic [JobKeyW-1:0] slot_job [DEPTH];
    logic [RunW-1:0]    slot_run [DEPTH];
    int unsigned        next_job;
    int unsigned        live;
    jte_out_t           pending_replies [$];
    int unsigned        mismatches;
    int unsigned        op_seen [8];
    int unsigned        status_seen [4];

    function new();
      foreach (slot_pid[i]) begin
        slot_pid[i] = '0;
        slot_job[i] = '0;
        slot_run[i] = RUN_UNDEFINED;
      end
      next_job = 1;
      live = 0;
      mismatches = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int find_entry(jte_in_t req);
      for (int i = 0; i < DEPTH; i++) begin
        case (req.opcode)
          OP_DEL_PID, OP_FIND_PID: begin
            if (req.pid_key != 0 && slot_pid[i] == req.pid_key) return i;
          end
          OP_DEL_JOB, OP_FIND_JOB: begin
            if (req.job_key != 0 && slot_pid[i] != 0 && slot_job[i] == req.job_key) return i;
          end
          OP_FOREGROUND: begin
            if (slot_pid[i] != 0 && slot_run[i] == RUN_FOREGROUND) return i;
          end
          default: ;
        endcase
      end
      return DEPTH;
    endfunction

    function jte_out_t apply_request(jte_in_t req);
      jte_out_t    rsp;
      int          slot;
      int unsigned top;
      rsp = '0;
      rsp.status = ST_NOT_FOUND;
      slot = DEPTH;
      case (req.opcode)
        OP_ADD: begin
          if (req.pid_key == 0) begin
            rsp.status = ST_BAD_PID;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (slot == DEPTH && slot_pid[i] == 0) slot = i;
            end
            if (slot == DEPTH) begin
              rsp.status = ST_FULL;
            end else begin
              slot_pid[slot] = req.pid_key;
              slot_run[slot] = req.run_state;
              slot_job[slot] = JobKeyW'(next_job);
              next_job = (next_job >= DEPTH) ? 1 : next_job + 1;
              live++;
              rsp.status = ST_OK;
              rsp.found_pid = req.pid_key;
              rsp.found_job = slot_job[slot];
              rsp.found_state = req.run_state;
            end
          end
        end
        OP_DEL_PID, OP_DEL_JOB, OP_FIND_PID, OP_FIND_JOB, OP_FOREGROUND: begin
          slot = find_entry(req);
          if (slot != DEPTH) begin
            rsp.status = ST_OK;
            rsp.found_pid = slot_pid[slot];
            rsp.found_job = slot_job[slot];
            rsp.found_state = slot_run[slot];
            if (req.opcode == OP_DEL_PID || req.opcode == OP_DEL_JOB) begin
              slot_pid[slot] = '0;
              slot_job[slot] = '0;
              slot_run[slot] = RUN_UNDEFINED;
              if (live > 0) live--;
              top = 0;
              foreach (slot_job[i]) begin
                if (slot_job[i] > top) top = slot_job[i];
              end
              next_job = (top + 1 > DEPTH) ? 1 : top + 1;
            end
          end
        end
        default: ;
      endcase
      rsp.live_count = CountOutW'(live);
      return rsp;
    endfunction

    function void note_request(jte_in_t req);
      op_seen[req.opcode]++;
      pending_replies.push_back(apply_request(req));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(jte_out_t got);
      jte_out_t want;
      if (pending_replies.size() == 0) begin
        $error("Result beat with nothing expected: status %0d, pid %0d", got.status,
               got.found_pid);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      status_seen[got.status]++;
      compare_field("status", want.status, got.status);
      compare_field("found_pid", want.found_pid, got.found_pid);
      compare_field("found_job", want.found_job, got.found_job);
      compare_field("found_state", want.found_state, got.found_state);
      compare_field("live_count", want.live_count, got.live_count);
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  jte_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  jte_out_t out_data_o;

  job_table_mirror mirror;
  int unsigned     send_idle_pct = 18;
  int unsigned     recv_idle_pct = 83;
  int unsigned     quiet_cycles = 0;

  job_table_engine #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) mirror.check_reply(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles without a beat.", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_request(input jte_in_t req);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(40, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.note_request(req);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [PidW-1:0] pid,
                         input logic [JobKeyW-1:0] job, input logic [RunW-1:0] run);
    jte_in_t req;
    req.opcode = op;
    req.pid_key = pid;
    req.job_key = job;
    req.run_state = run;
    send_request(req);
  endtask

  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mirror.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PidW-1:0] random_pid();
    case ($urandom_range(3))
      0: return '0;
      1: return PidW'($urandom_range(8, 1));
      default: return PidW'($urandom);
    endcase
  endfunction

  function automatic jte_in_t pick_request(int unsigned add_weight);
    jte_in_t     req;
    int unsigned roll;
    int unsigned idx;
    roll = $urandom_range(99);
    req.run_state = RunW'($urandom_range(3));
    req.job_key = JobKeyW'($urandom_range(17));
    req.pid_key = random_pid();
    if (roll < add_weight) begin
      req.opcode = OP_ADD;
    end else if (roll < 97) begin
      case ($urandom_range(4))
        0: req.opcode = OP_DEL_PID;
        1: req.opcode = OP_DEL_JOB;
        2: req.opcode = OP_FIND_PID;
        3: req.opcode = OP_FIND_JOB;
        default: req.opcode = OP_FOREGROUND;
      endcase
    end else begin
      req.opcode = $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
    end
    if (req.opcode == OP_ADD) begin
      if ($urandom_range(99) < 90) begin
        req.pid_key = ($urandom_range(3) == 0) ? PidW'($urandom_range(8, 1)) : PidW'($urandom);
      end
      if ($urandom_range(99) < 5) req.pid_key = '0;
    end else if (mirror.live > 0 && $urandom_range(99) < 75) begin
      do idx = $urandom_range(DEPTH - 1); while (mirror.slot_pid[idx] == 0);
      req.pid_key = mirror.slot_pid[idx];
      req.job_key = mirror.slot_job[idx];
    end
    return req;
  endfunction

  initial begin
    int unsigned add_weight;
    logic [PidW-1:0] pid;
    mirror = new();
    add_weight = 40;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(OP_FOREGROUND, '0, '0, RUN_UNDEFINED);
    send_op(OP_DEL_PID, '0, '0, RUN_UNDEFINED);
    send_op(OP_FIND_JOB, '0, '0, RUN_UNDEFINED);
    send_op(OP_UNUSED_6, PID_MAX, JobKeyW'(17), RUN_STOPPED);
    send_op(OP_ADD, '0, '0, RUN_FOREGROUND);
    for (int i = 0; i < DEPTH; i++) begin
      pid = (i == 0) ? PID_MAX : (i < 3) ? PidW'(1) : PidW'(22'h155555 + i * 7919);
      send_op(OP_ADD, pid, JobKeyW'(i), RunW'(i));
    end
    send_op(OP_ADD, PidW'(5), '0, RUN_BACKGROUND);
    send_op(OP_FIND_PID, PidW'(1), '0, RUN_UNDEFINED);
    send_op(OP_FOREGROUND, '0, '0, RUN_UNDEFINED);
    send_op(OP_DEL_JOB, '0, JobKeyW'(16), RUN_UNDEFINED);
    send_op(OP_ADD, PidW'(22'h2AAAAA), '0, RUN_BACKGROUND);
    send_op(OP_FIND_JOB, '0, JobKeyW'(17), RUN_UNDEFINED);
    send_op(OP_DEL_PID, PID_MAX, '0, RUN_UNDEFINED);
    wait_for_replies();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 83 : 0;
      recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 18 : 0;
      for (int n = 0; n < 310; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(3))
            0: add_weight = 15;
            1: add_weight = 30;
            2: add_weight = 50;
            default: add_weight = 70;
          endcase
        end
        if (n % 100 == 99) wait_for_replies();
        send_request(pick_request(add_weight));
      end
      wait_for_replies();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Requests: %0d adds, %0d deletes, %0d lookups, %0d undefined opcodes.",
             mirror.op_seen[OP_ADD], mirror.op_seen[OP_DEL_PID] + mirror.op_seen[OP_DEL_JOB],
             mirror.op_seen[OP_FIND_PID] + mirror.op_seen[OP_FIND_JOB] +
             mirror.op_seen[OP_FOREGROUND],
             mirror.op_seen[OP_UNUSED_6] + mirror.op_seen[OP_UNUSED_7]);
    $display("Results: %0d ok, %0d not found, %0d table full, %0d invalid pid.",
             mirror.status_seen[ST_OK], mirror.status_seen[ST_NOT_FOUND],
             mirror.status_seen[ST_FULL], mirror.status_seen[ST_BAD_PID]);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/jte_pkg.sv
hw/rtl/job_table_engine.sv
sim/job_table_engine_test.sv
